// File: src/swrlrr_pkg.sv
// Shared types and constants of the sliding-window rate limiter with round-robin forwarding.
`default_nettype none
package swrlrr_pkg;

    localparam int unsigned MAX_DEST   = 16;
    localparam int unsigned DEST_W     = 4;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned RATE_W     = 11;
    localparam int unsigned NDEST_W    = 5;
    localparam int unsigned CNT_OUT_W  = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 56;
    localparam int unsigned M_TDATA_W  = 32;
    localparam int unsigned STATUS_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DEST     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES    = 2'd3;

    localparam logic [RATE_W-1:0]     RST_RATE_LIMIT   = 11'd1024;
    localparam logic [TIME_W-1:0]     RST_WINDOW_TICKS = 32'd1000000;
    localparam logic [NDEST_W-1:0]    RST_NUM_DEST     = 5'd1;
    localparam logic [LEN_W-1:0]      RST_MAX_BYTES    = 16'd1024;

    typedef enum logic [0:0] {
        CMD_ARRIVAL = 1'b0,
        CMD_OUTCOME = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_FORWARD    = 3'd0,
        ST_RETRY      = 3'd1,
        ST_LIMITED    = 3'd2,
        ST_OVERSIZE   = 3'd3,
        ST_RX_ERROR   = 3'd4,
        ST_BUSY       = 3'd5,
        ST_RECORDED   = 3'd6,
        ST_UNEXPECTED = 3'd7
    } t_status;

    typedef enum logic [0:0] {
        FSM_IDLE = 1'b0,
        FSM_RUN  = 1'b1
    } t_state;

endpackage
`default_nettype wire

// File: src/sliding_window_rate_limited_round_robin_unit.sv
// Top level: send-time log in a synchronous memory, expiry sequencer and round-robin selection.
//
// Input channel s_axis carries one command item: an arrival (time, length) or a send
// outcome report. Output channel m_axis returns exactly one result item per input item.
// The configuration port writes the four registers; the user must do so only while the
// block is idle, as the block itself does not enforce it. The result is registered after
// the decision cycle, which an arrival precedes with one expiry step for each logged send
// time that leaves the window; the expiry loop reads one entry of the log memory per cycle.
// A new item is taken only once the last one has been captured and decided in the
// decision cycle. Each logged time expires only once.
// One item is in work at a time: s_axis_tready is high while no item is in work.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls with a result still held, the next result waits in the
// decision cycle until the output register frees.
// Reset (synchronous, active low) empties the log, clears the rotation and the pending
// send, and loads the register defaults. The log memory needs no clearing pass: only
// entries written since reset are read.
`default_nettype none
module sliding_window_rate_limited_round_robin_unit #(
    parameter int unsigned MAX_RATE = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // tdata: now_us[31:0], packet_length[47:32], send_ok[48], zero[55:49]
    input  wire logic [swrlrr_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: command
    input  wire logic                                  s_axis_tuser,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata: dest_index[3:0], send_length[19:4], window_count[30:20], zero[31]
    output logic [swrlrr_pkg::M_TDATA_W-1:0]           m_axis_tdata,
    // tuser: status
    output logic [swrlrr_pkg::STATUS_W-1:0]            m_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    input  wire logic                                  i_cfg_we,
    input  wire logic [swrlrr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [swrlrr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned SW = (MAX_RATE > 1) ? $clog2(MAX_RATE) : 1;
    localparam int unsigned CW = $clog2(MAX_RATE + 1);
    localparam int unsigned AW = SW + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_RATE - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_RATE);
    localparam logic [AW-1:0] DEPTH_A   = AW'(MAX_RATE);

    // configuration
    logic [swrlrr_pkg::RATE_W-1:0]  r_rate_limit;
    logic [swrlrr_pkg::TIME_W-1:0]  r_window;
    logic [swrlrr_pkg::NDEST_W-1:0] r_num_dest;
    logic [swrlrr_pkg::LEN_W-1:0]   r_max_bytes;

    // control state
    swrlrr_pkg::t_state             r_state, n_state;
    logic [SW-1:0]                  r_oldest, n_oldest;
    logic [CW-1:0]                  r_count, n_count;
    logic [swrlrr_pkg::DEST_W-1:0]  r_next_dest, n_next_dest;
    logic                           r_await, n_await;
    logic [swrlrr_pkg::LEN_W-1:0]   r_pend_len, n_pend_len;
    logic                           r_out_valid, n_out_valid;

    // item in work
    swrlrr_pkg::t_cmd               r_cmd;
    logic [swrlrr_pkg::TIME_W-1:0]  r_now;
    logic [swrlrr_pkg::LEN_W-1:0]   r_len;
    logic                           r_ok;

    // output payload
    logic [swrlrr_pkg::M_TDATA_W-1:0] r_out_tdata;
    logic [swrlrr_pkg::STATUS_W-1:0]  r_out_tuser;

    // send-time log
    logic [swrlrr_pkg::TIME_W-1:0]  r_mem [MAX_RATE];
    logic [swrlrr_pkg::TIME_W-1:0]  r_rd_data;
    logic                           mem_we;
    logic [SW-1:0]                  mem_waddr;

    logic                           emit_ok;
    logic                           emit;
    logic                           expired;
    logic                           expire_step;
    logic [31:0]                    limit;
    logic [swrlrr_pkg::DEST_W:0]    dest_n;
    logic [swrlrr_pkg::DEST_W-1:0]  dest_cur;
    logic [swrlrr_pkg::DEST_W:0]    dest_inc;
    logic [SW-1:0]                  oldest_after;
    logic [AW-1:0]                  slot_sum;
    logic [SW-1:0]                  log_slot;
    swrlrr_pkg::t_status            res_status;
    logic [swrlrr_pkg::DEST_W-1:0]  res_dest;
    logic [swrlrr_pkg::LEN_W-1:0]   res_len;

    assign s_axis_tready = (r_state == swrlrr_pkg::FSM_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;
    assign emit_ok       = !r_out_valid || m_axis_tready;

    always_comb begin
        limit = (32'(r_rate_limit) > 32'(MAX_RATE)) ? 32'(MAX_RATE) : 32'(r_rate_limit);

        if (r_num_dest == '0) begin
            dest_n = (swrlrr_pkg::DEST_W + 1)'(1);
        end else if (32'(r_num_dest) > 32'(swrlrr_pkg::MAX_DEST)) begin
            dest_n = (swrlrr_pkg::DEST_W + 1)'(swrlrr_pkg::MAX_DEST);
        end else begin
            dest_n = (swrlrr_pkg::DEST_W + 1)'(r_num_dest);
        end
        dest_cur = ({1'b0, r_next_dest} < dest_n) ? r_next_dest : '0;
        dest_inc = {1'b0, dest_cur} + 1'b1;

        oldest_after = (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
        slot_sum     = {1'b0, r_oldest} + AW'(r_count);
        if (r_count == FULL_CNT) begin
            log_slot = r_oldest;
        end else if (slot_sum >= DEPTH_A) begin
            log_slot = SW'(slot_sum - DEPTH_A);
        end else begin
            log_slot = SW'(slot_sum);
        end

        expired     = (r_now - r_rd_data) > r_window;
        expire_step = (r_cmd == swrlrr_pkg::CMD_ARRIVAL) && !r_await && (r_len != '0)
                      && (r_len <= r_max_bytes) && (r_count != '0) && expired;
    end

    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        n_count     = r_count;
        n_next_dest = r_next_dest;
        n_await     = r_await;
        n_pend_len  = r_pend_len;
        n_out_valid = r_out_valid && !m_axis_tready;
        mem_we      = 1'b0;
        mem_waddr   = log_slot;
        emit        = 1'b0;
        res_status  = swrlrr_pkg::ST_BUSY;
        res_dest    = '0;
        res_len     = '0;

        case (r_state)
            swrlrr_pkg::FSM_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = swrlrr_pkg::FSM_RUN;
                end
            end
            swrlrr_pkg::FSM_RUN: begin
                if (expire_step) begin
                    n_oldest = oldest_after;
                    n_count  = r_count - 1'b1;
                end else if (emit_ok) begin
                    emit        = 1'b1;
                    n_state     = swrlrr_pkg::FSM_IDLE;
                    n_out_valid = 1'b1;
                    if (r_cmd == swrlrr_pkg::CMD_ARRIVAL) begin
                        if (r_await) begin
                            res_status = swrlrr_pkg::ST_BUSY;
                        end else if (r_len == '0) begin
                            res_status = swrlrr_pkg::ST_RX_ERROR;
                        end else if (r_len > r_max_bytes) begin
                            res_status = swrlrr_pkg::ST_OVERSIZE;
                        end else if (32'(r_count) < limit) begin
                            res_status  = swrlrr_pkg::ST_FORWARD;
                            res_dest    = dest_cur;
                            res_len     = r_len;
                            n_next_dest = (dest_inc >= dest_n) ? '0
                                          : swrlrr_pkg::DEST_W'(dest_inc);
                            n_pend_len  = r_len;
                            n_await     = 1'b1;
                        end else begin
                            res_status = swrlrr_pkg::ST_LIMITED;
                        end
                    end else begin
                        if (!r_await) begin
                            res_status = swrlrr_pkg::ST_UNEXPECTED;
                        end else if (r_ok) begin
                            res_status = swrlrr_pkg::ST_RECORDED;
                            mem_we     = 1'b1;
                            n_await    = 1'b0;
                            if (r_count == FULL_CNT) begin
                                n_oldest = oldest_after;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end else begin
                            res_status  = swrlrr_pkg::ST_RETRY;
                            res_dest    = dest_cur;
                            res_len     = r_pend_len;
                            n_next_dest = (dest_inc >= dest_n) ? '0
                                          : swrlrr_pkg::DEST_W'(dest_inc);
                        end
                    end
                end
            end
            default: begin
                n_state = swrlrr_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swrlrr_pkg::FSM_IDLE;
            r_oldest    <= '0;
            r_count     <= '0;
            r_next_dest <= '0;
            r_await     <= 1'b0;
            r_pend_len  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_next_dest <= n_next_dest;
            r_await     <= n_await;
            r_pend_len  <= n_pend_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_limit <= swrlrr_pkg::RST_RATE_LIMIT;
            r_window     <= swrlrr_pkg::RST_WINDOW_TICKS;
            r_num_dest   <= swrlrr_pkg::RST_NUM_DEST;
            r_max_bytes  <= swrlrr_pkg::RST_MAX_BYTES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swrlrr_pkg::CFG_RATE_LIMIT:   r_rate_limit <= i_cfg_data[swrlrr_pkg::RATE_W-1:0];
                swrlrr_pkg::CFG_WINDOW_TICKS: r_window     <= i_cfg_data[swrlrr_pkg::TIME_W-1:0];
                swrlrr_pkg::CFG_NUM_DEST:     r_num_dest   <= i_cfg_data[swrlrr_pkg::NDEST_W-1:0];
                swrlrr_pkg::CFG_MAX_BYTES:    r_max_bytes  <= i_cfg_data[swrlrr_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // item capture and result register
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= swrlrr_pkg::t_cmd'(s_axis_tuser);
            r_now <= s_axis_tdata[31:0];
            r_len <= s_axis_tdata[47:32];
            r_ok  <= s_axis_tdata[48];
        end
        if (emit) begin
            r_out_tuser <= res_status;
            r_out_tdata <= {1'b0, swrlrr_pkg::CNT_OUT_W'(n_count), res_len, res_dest};
        end
    end

    // log memory; read port follows the next oldest slot, write forwarded on collision
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_now;
        end
        if (mem_we && (mem_waddr == n_oldest)) begin
            r_rd_data <= r_now;
        end else begin
            r_rd_data <= r_mem[n_oldest];
        end
    end

endmodule
`default_nettype wire

// File: src/swrlrr_chk.sv
// Port-level checker for the rate limiter, bound to the top level.
`default_nettype none
module swrlrr_chk (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  s_axis_tvalid,
    input wire logic                                  s_axis_tready,
    input wire logic [swrlrr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input wire logic [swrlrr_pkg::STATUS_W-1:0]       m_axis_tuser,
    input wire logic                                  m_axis_tvalid,
    input wire logic                                  m_axis_tready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in work");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle after reset");

    a_no_send_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != swrlrr_pkg::ST_FORWARD)
        && (m_axis_tuser != swrlrr_pkg::ST_RETRY) |-> m_axis_tdata[19:0] == '0)
        else $error("destination or length set on a non-send result");

    a_send_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((m_axis_tuser == swrlrr_pkg::ST_FORWARD)
        || (m_axis_tuser == swrlrr_pkg::ST_RETRY)) |-> m_axis_tdata[19:4] != '0)
        else $error("send result with zero length");

endmodule

bind sliding_window_rate_limited_round_robin_unit swrlrr_chk u_swrlrr_chk (.*);
`default_nettype wire

// File: sim/rate_limiter_checker.sv
// Checker: watches the item channels and the register port, predicts each decision, compares.
module rate_limiter_checker
    import swrlrr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,
    input  logic [STATUS_W-1:0]   i_m_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [31:0]           o_mismatches,
    output logic [31:0]           o_outstanding,
    output logic [31:0]           o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LOG_DEPTH = 1024;

    typedef struct packed {
        t_status              status;
        logic [DEST_W-1:0]    dest;
        logic [LEN_W-1:0]     len;
        logic [CNT_OUT_W-1:0] count;
    } t_decision;

    logic [TIME_W-1:0]    send_log [0:LOG_DEPTH-1];
    logic [9:0]           log_head;
    logic [10:0]          log_count;
    logic [DEST_W-1:0]    rr_next;
    logic                 outcome_due;
    logic [LEN_W-1:0]     kept_len;

    logic [RATE_W-1:0]    cfg_limit;
    logic [TIME_W-1:0]    cfg_window;
    logic [NDEST_W-1:0]   cfg_ndest;
    logic [LEN_W-1:0]     cfg_max;

    t_decision            expected_decisions [$];
    int unsigned          mismatches;
    int unsigned          checked;

    function automatic logic [DEST_W-1:0] rotate_destination();
        int unsigned n;
        int unsigned d;
        n = (cfg_ndest == 0) ? 1 : ((cfg_ndest > MAX_DEST) ? MAX_DEST : cfg_ndest);
        d = (rr_next < n) ? rr_next : 0;
        rr_next = DEST_W'((d + 1 >= n) ? 0 : d + 1);
        return DEST_W'(d);
    endfunction

    function automatic t_decision limiter_decision(input logic cmd, input logic [31:0] now,
                                                   input logic [15:0] len, input logic ok);
        t_decision   d;
        int unsigned limit;
        int unsigned slot;
        d.status = ST_BUSY;
        d.dest   = '0;
        d.len    = '0;
        if (cmd == CMD_ARRIVAL) begin
            if (outcome_due) begin
                d.status = ST_BUSY;
            end else if (len == 0) begin
                d.status = ST_RX_ERROR;
            end else if (len > cfg_max) begin
                d.status = ST_OVERSIZE;
            end else begin
                limit = (cfg_limit > LOG_DEPTH) ? LOG_DEPTH : cfg_limit;
                while (log_count != 0 && TIME_W'(now - send_log[log_head]) > cfg_window) begin
                    log_head  = log_head + 10'd1;
                    log_count = log_count - 11'd1;
                end
                if (log_count < limit) begin
                    d.status    = ST_FORWARD;
                    d.dest      = rotate_destination();
                    d.len       = len;
                    kept_len    = len;
                    outcome_due = 1'b1;
                end else begin
                    d.status = ST_LIMITED;
                end
            end
        end else begin
            if (!outcome_due) begin
                d.status = ST_UNEXPECTED;
            end else if (ok) begin
                if (log_count >= LOG_DEPTH) begin
                    log_head  = log_head + 10'd1;
                    log_count = log_count - 11'd1;
                end
                slot = (int'(log_head) + int'(log_count)) % LOG_DEPTH;
                send_log[slot] = now;
                log_count   = log_count + 11'd1;
                outcome_due = 1'b0;
                d.status    = ST_RECORDED;
            end else begin
                d.status = ST_RETRY;
                d.dest   = rotate_destination();
                d.len    = kept_len;
            end
        end
        d.count = log_count;
        return d;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_decision want;
        t_decision got;
        if (!i_rst_n) begin
            log_head    = '0;
            log_count   = '0;
            rr_next     = '0;
            outcome_due = 1'b0;
            kept_len    = '0;
            cfg_limit   = RST_RATE_LIMIT;
            cfg_window  = RST_WINDOW_TICKS;
            cfg_ndest   = RST_NUM_DEST;
            cfg_max     = RST_MAX_BYTES;
            mismatches  = 0;
            checked     = 0;
            expected_decisions.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RATE_LIMIT:   cfg_limit  = i_cfg_data[RATE_W-1:0];
                    CFG_WINDOW_TICKS: cfg_window = i_cfg_data[TIME_W-1:0];
                    CFG_NUM_DEST:     cfg_ndest  = i_cfg_data[NDEST_W-1:0];
                    CFG_MAX_BYTES:    cfg_max    = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                want = limiter_decision(i_s_tuser, i_s_tdata[31:0], i_s_tdata[47:32],
                                        i_s_tdata[48]);
                expected_decisions.insert(expected_decisions.size(), want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status = t_status'(i_m_tuser);
                got.dest   = i_m_tdata[DEST_W-1:0];
                got.len    = i_m_tdata[DEST_W+LEN_W-1:DEST_W];
                got.count  = i_m_tdata[DEST_W+LEN_W+CNT_OUT_W-1:DEST_W+LEN_W];
                if (expected_decisions.size() == 0) begin
                    if (mismatches < 10)
                        $display("%t: result item with nothing expected: status %0d", $realtime,
                                 got.status);
                    mismatches++;
                end else begin
                    want = expected_decisions[0];
                    expected_decisions.delete(0);
                    checked++;
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display({"%t: mismatch exp/got status %0d/%0d dest %0d/%0d",
                                      " len %0d/%0d count %0d/%0d"},
                                     $realtime, want.status, got.status, want.dest, got.dest,
                                     want.len, got.len, want.count, got.count);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_decisions.size();
        o_checked     <= checked;
    end

endmodule

// File: sim/testbench.sv
// Testbench top: clock, reset, item and register stimulus, receiver stalls, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import swrlrr_pkg::*;

    localparam int unsigned ITEM_TARGET = 1030;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned SETTLE      = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    wire [M_TDATA_W-1:0]   m_axis_tdata;
    wire [STATUS_W-1:0]    m_axis_tuser;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    wire [31:0]            mismatches;
    wire [31:0]            outstanding;
    wire [31:0]            checked;

    bit                    gaps_on = 1'b1;
    int unsigned           hold_requests = 0;
    int unsigned           items_sent = 0;
    int unsigned           settings_count = 0;
    logic [31:0]           now_ticks = '0;
    logic [15:0]           max_len = RST_MAX_BYTES;

    sliding_window_rate_limited_round_robin_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    rate_limiter_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int unsigned stall_left;
        int unsigned hold_served;
        stall_left  = 0;
        hold_served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (gaps_on) stall_left = gap_len();
            end
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [31:0] now, input logic [15:0] len,
                             input logic ok);
        int unsigned gap;
        s_axis_tdata  <= {7'd0, ok, len, now};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        gap = gaps_on ? gap_len() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input t_cmd cmd, input logic ok);
        int unsigned r;
        logic [15:0] len;
        r = $urandom_range(0, 19);
        if (r < 2)       now_ticks = now_ticks;
        else if (r < 12) now_ticks = now_ticks + $urandom_range(1, 40);
        else if (r < 17) now_ticks = now_ticks + $urandom_range(40, 600);
        else if (r < 19) now_ticks = now_ticks + $urandom_range(600, 20000);
        else             now_ticks = now_ticks + $urandom;
        case ($urandom_range(0, 15))
            0:       len = '0;
            1:       len = 16'd1;
            2:       len = max_len;
            3:       len = max_len + 16'd1;
            4:       len = 16'($urandom_range(0, 65535));
            default: len = 16'($urandom_range(1, (max_len == 0) ? 1 : max_len));
        endcase
        send_item(cmd, now_ticks, len, ok);
    endtask

    // stop offering, let every decision arrive, then let the channels settle quietly
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_MAX_BYTES) max_len = value[15:0];
    endtask

    initial begin : stimulus
        int unsigned phase_end;
        int unsigned r;
        int unsigned fails;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: limit 1024, window 1e6, one destination, 1024 bytes
        send_item(CMD_OUTCOME, 32'd0, 16'd0, 1'b1);
        send_item(CMD_OUTCOME, 32'd0, 16'hFFFF, 1'b0);
        send_item(CMD_ARRIVAL, 32'd0, 16'd0, 1'b0);
        send_item(CMD_ARRIVAL, 32'd0, 16'd1025, 1'b0);
        send_item(CMD_ARRIVAL, 32'd0, 16'hFFFF, 1'b1);
        send_item(CMD_ARRIVAL, 32'd0, 16'd1, 1'b0);
        send_item(CMD_ARRIVAL, 32'd0, 16'd5, 1'b0);
        send_item(CMD_OUTCOME, 32'd0, 16'd0, 1'b0);
        send_item(CMD_OUTCOME, 32'd0, 16'd0, 1'b1);
        send_item(CMD_ARRIVAL, 32'd1000000, 16'd1024, 1'b0);
        send_item(CMD_OUTCOME, 32'd1000000, 16'd0, 1'b1);
        send_item(CMD_ARRIVAL, 32'd1000001, 16'd77, 1'b0);
        send_item(CMD_OUTCOME, 32'd1000001, 16'd0, 1'b1);
        write_reg(CFG_RATE_LIMIT, 32'd2);
        write_reg(CFG_NUM_DEST, 32'd0);
        write_reg(CFG_WINDOW_TICKS, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_BYTES, 32'd65535);
        settings_count++;
        send_item(CMD_ARRIVAL, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        write_reg(CFG_RATE_LIMIT, 32'd2047);
        write_reg(CFG_NUM_DEST, 32'd31);
        settings_count++;
        send_item(CMD_ARRIVAL, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_item(CMD_OUTCOME, 32'hFFFF_FFFF, 16'd0, 1'b0);
        send_item(CMD_OUTCOME, 32'hFFFF_FFFF, 16'd0, 1'b0);
        send_item(CMD_OUTCOME, 32'd0, 16'd0, 1'b1);
        write_reg(CFG_WINDOW_TICKS, 32'd0);
        write_reg(CFG_RATE_LIMIT, 32'd0);
        write_reg(CFG_MAX_BYTES, 32'd0);
        settings_count++;
        send_item(CMD_ARRIVAL, 32'd0, 16'd1, 1'b0);
        write_reg(CFG_MAX_BYTES, 32'd1);
        settings_count++;
        send_item(CMD_ARRIVAL, 32'd0, 16'd1, 1'b0);
        write_reg(CFG_NUM_DEST, 32'd3);
        write_reg(CFG_RATE_LIMIT, 32'd1);
        settings_count++;
        send_item(CMD_ARRIVAL, 32'd1, 16'd1, 1'b0);
        send_item(CMD_OUTCOME, 32'd1, 16'd0, 1'b1);
        send_item(CMD_ARRIVAL, 32'd1, 16'd1, 1'b0);
        now_ticks = 32'd1;

        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 7))
                0:          write_reg(CFG_RATE_LIMIT, 32'd0);
                1:          write_reg(CFG_RATE_LIMIT, 32'd1);
                2, 3, 4, 5: write_reg(CFG_RATE_LIMIT, $urandom_range(2, 12));
                6:          write_reg(CFG_RATE_LIMIT, 32'd1024);
                default:    write_reg(CFG_RATE_LIMIT, $urandom_range(1025, 2047));
            endcase
            case ($urandom_range(0, 7))
                0:       write_reg(CFG_WINDOW_TICKS, 32'd0);
                1:       write_reg(CFG_WINDOW_TICKS, 32'd1);
                2, 3, 4: write_reg(CFG_WINDOW_TICKS, $urandom_range(5, 300));
                5:       write_reg(CFG_WINDOW_TICKS, $urandom_range(300, 5000));
                6:       write_reg(CFG_WINDOW_TICKS, 32'hFFFF_FFFF);
                default: write_reg(CFG_WINDOW_TICKS, $urandom);
            endcase
            case ($urandom_range(0, 7))
                6:       write_reg(CFG_NUM_DEST, 32'd0);
                7:       write_reg(CFG_NUM_DEST, $urandom_range(17, 31));
                default: write_reg(CFG_NUM_DEST, $urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 15))
                0:              write_reg(CFG_MAX_BYTES, 32'd0);
                1:              write_reg(CFG_MAX_BYTES, 32'd1);
                2, 3, 4, 5, 6:  write_reg(CFG_MAX_BYTES, $urandom_range(64, 2000));
                7, 8, 9, 10:    write_reg(CFG_MAX_BYTES, 32'd65535);
                default:        write_reg(CFG_MAX_BYTES, $urandom_range(0, 65535));
            endcase
            settings_count++;
            gaps_on = (p % 3) != 2;
            if (p == 1) hold_requests++;
            phase_end = items_sent + ITEM_TARGET / PHASES;
            while (items_sent < phase_end) begin
                r = $urandom_range(0, 19);
                if (r < 15) begin
                    send_random(CMD_ARRIVAL, 1'($urandom_range(0, 1)));
                    fails = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
                    repeat (fails) send_random(CMD_OUTCOME, 1'b0);
                    send_random(CMD_OUTCOME, 1'b1);
                end else if (r < 17) begin
                    send_random(CMD_ARRIVAL, 1'($urandom_range(0, 1)));
                    send_random(CMD_ARRIVAL, 1'($urandom_range(0, 1)));
                end else begin
                    send_random(CMD_OUTCOME, 1'($urandom_range(0, 1)));
                end
            end
        end

        drain();
        $display("Ran %0d items under %0d register settings, %0d decisions compared.",
                 items_sent, settings_count, checked);
        $display("Included one %0d-cycle receiver hold-off with the sender still offering.",
                 LONG_HOLD);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
